[hw/rtl/tirf_pkg.sv]
`timescale 1ns / 1ps

package tirf_pkg;

  typedef enum logic [1:0] {
    ACT_DATA = 2'd0,
    ACT_EOF  = 2'd1,
    ACT_EOT  = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HEAD = 6'b000010,
    PH_DATA = 6'b000100,
    PH_PAD  = 6'b001000,
    PH_TAIL = 6'b010000,
    PH_MARK = 6'b100000
  } phase_t;

  // register indexes on the config port
  typedef enum logic {
    REG_BLOCK_FACTOR = 1'b0,
    REG_PAD_LAST     = 1'b1
  } reg_idx_t;

  // pending marker word: bits 1:0 tape mark count, bit 2 end of medium
  localparam logic [2:0] MK_NONE     = 3'b000;
  localparam logic [2:0] MK_EOF      = 3'b001;
  localparam logic [2:0] MK_EOT      = 3'b110;

  localparam logic [7:0] TAPE_MARK_BYTE = 8'h00;
  localparam logic [7:0] EOM_BYTE       = 8'hFF;
  localparam logic [7:0] PAD_BYTE       = 8'h00;
  localparam int         LEN_BYTES      = 4;

  localparam logic [4:0] BF_RESET  = 5'd1;
  localparam logic       PAD_RESET = 1'b1;

  // result of one accepted item, as it enters the output register
  typedef struct packed {
    logic       valid;
    logic       use_mem;
    logic [7:0] data;
    logic       obj_end;
    logic       refused;
  } res_t;

  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

endpackage

[hw/rtl/tape_image_record_framer.sv]
`timescale 1ns / 1ps
// a result is registered into the output register on its item's transfer
// one item per cycle while in_ready is high; the record store does at most one access (write or read) per item
// a data byte writes the store, a data-phase tick reads it; the read data lands with the result
// reset clears the sequencer, fill count, pending markers and config to their defaults
// store contents are undefined after reset; only bytes below the fill count are ever read
module tape_image_record_framer #(
  parameter int BUFFER_BYTES = 8192,
  parameter int BLOCK_UNIT = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_object_end,
  output logic        out_refused,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tirf_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  logic [4:0] bf_r;
  logic       pad_r;
  logic       accept;
  reg_idx_t   reg_idx;

  res_t       res;
  store_ctl_t st;
  logic [AW-1:0] st_addr;
  logic [7:0] st_wdata;
  logic [7:0] rdata;

  logic       out_valid_r;
  logic       use_mem_r;
  logic [7:0] byte_r;
  logic       end_r;
  logic       refused_r;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bf_r  <= BF_RESET;
      pad_r <= PAD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_BLOCK_FACTOR: bf_r  <= pwdata[4:0];
        REG_PAD_LAST:     pad_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_FACTOR: prdata = {27'd0, bf_r};
      REG_PAD_LAST:     prdata = {31'd0, pad_r};
      default:          prdata = '0;
    endcase
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  tirf_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .BLOCK_UNIT  (BLOCK_UNIT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .action      (action_t'(in_action)),
    .data_byte   (in_data_byte),
    .block_factor(bf_r),
    .pad_last    (pad_r),
    .res         (res),
    .st          (st),
    .st_addr     (st_addr),
    .st_wdata    (st_wdata)
  );

  tirf_store #(
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk  (clk),
    .st   (st),
    .addr (st_addr),
    .wdata(st_wdata),
    .rdata(rdata)
  );

  // output register; store read data holds while the result waits since no new read is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      use_mem_r <= res.use_mem;
      byte_r    <= res.data;
      end_r     <= res.obj_end;
      refused_r <= res.refused;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = use_mem_r ? rdata : byte_r;
  assign out_object_end = end_r;
  assign out_refused    = refused_r;

endmodule

[hw/rtl/tirf_store.sv]
`timescale 1ns / 1ps

module tirf_store #(
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  tirf_pkg::store_ctl_t st,
  input  logic [AW-1:0]        addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);
  import tirf_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (st.we) begin
      mem[addr] <= wdata;
    end
    if (st.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/tirf_ctrl.sv]
`timescale 1ns / 1ps

module tirf_ctrl #(
  parameter int BUFFER_BYTES = 8192,
  parameter int BLOCK_UNIT = 512,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int CW = $clog2(BUFFER_BYTES + 1),
  localparam int PW = $clog2(31 * BLOCK_UNIT + BUFFER_BYTES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  tirf_pkg::action_t    action,
  input  logic [7:0]           data_byte,
  input  logic [4:0]           block_factor,
  input  logic                 pad_last,
  output tirf_pkg::res_t       res,
  output tirf_pkg::store_ctl_t st,
  output logic [AW-1:0]        st_addr,
  output logic [7:0]           st_wdata
);
  import tirf_pkg::*;

  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [2:0]    mark_r, mark_nxt;

  logic [4:0]    units;
  logic [PW-1:0] prod;
  logic [CW-1:0] size;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] fill_inc;
  logic [31:0]   len32;
  logic [7:0]    len_byte;
  logic [2:0]    mark_dec;
  logic [2:0]    mk;

  // record size, saturated to the store depth
  always_comb begin
    units = (block_factor == 5'd0) ? 5'd1 : block_factor;
    prod  = PW'(units) * PW'(BLOCK_UNIT);
    size  = (prod > PW'(BUFFER_BYTES)) ? CW'(BUFFER_BYTES) : prod[CW-1:0];
  end

  assign pos_inc  = pos_r + CW'(1);
  assign fill_inc = fill_r + CW'(1);
  assign len32    = 32'(len_r);
  assign len_byte = len32[8*pos_r[1:0] +: 8];
  assign mark_dec = (mark_r[1:0] != 2'd0) ? (mark_r - 3'd1) : MK_NONE;
  assign mk       = (action == ACT_EOF) ? MK_EOF : MK_EOT;
  assign st_wdata = data_byte;

  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    mark_nxt  = mark_r;
    res       = '0;
    st        = '0;
    st_addr   = fill_r[AW-1:0];
    if (accept) begin
      unique case (action)
        ACT_DATA: begin
          if (phase_r != PH_IDLE) begin
            res.valid   = 1'b1;
            res.refused = 1'b1;
          end else begin
            st.we    = (fill_r < CW'(BUFFER_BYTES));
            fill_nxt = fill_inc;
            if (fill_inc >= size) begin
              len_nxt   = fill_inc;
              pos_nxt   = '0;
              phase_nxt = PH_HEAD;
            end
          end
        end
        ACT_EOF, ACT_EOT: begin
          if (phase_r == PH_IDLE) begin
            mark_nxt = mk;
            pos_nxt  = '0;
            if (fill_r != '0) begin
              len_nxt   = (pad_last && (fill_r < size)) ? size : fill_r;
              phase_nxt = PH_HEAD;
            end else begin
              phase_nxt = PH_MARK;
            end
          end
        end
        ACT_TICK: begin
          unique case (phase_r)
            PH_IDLE: begin
            end
            PH_HEAD: begin
              res.valid = 1'b1;
              res.data  = len_byte;
              if (pos_inc >= CW'(LEN_BYTES)) begin
                pos_nxt   = '0;
                phase_nxt = PH_DATA;
              end else begin
                pos_nxt = pos_inc;
              end
            end
            PH_DATA: begin
              res.valid = 1'b1;
              // bytes past the fill count go out as zero, no store read
              if ((pos_r < fill_r) && (pos_r < CW'(BUFFER_BYTES))) begin
                st.re       = 1'b1;
                st_addr     = pos_r[AW-1:0];
                res.use_mem = 1'b1;
              end
              if (pos_inc >= len_r) begin
                pos_nxt   = '0;
                phase_nxt = len_r[0] ? PH_PAD : PH_TAIL;
              end else begin
                pos_nxt = pos_inc;
              end
            end
            PH_PAD: begin
              res.valid = 1'b1;
              res.data  = PAD_BYTE;
              pos_nxt   = '0;
              phase_nxt = PH_TAIL;
            end
            PH_TAIL: begin
              res.valid = 1'b1;
              res.data  = len_byte;
              if (pos_inc >= CW'(LEN_BYTES)) begin
                res.obj_end = 1'b1;
                fill_nxt    = '0;
                pos_nxt     = '0;
                phase_nxt   = (mark_r != MK_NONE) ? PH_MARK : PH_IDLE;
              end else begin
                pos_nxt = pos_inc;
              end
            end
            PH_MARK: begin
              res.valid = 1'b1;
              res.data  = (mark_r[1:0] != 2'd0) ? TAPE_MARK_BYTE : EOM_BYTE;
              if (pos_inc >= CW'(LEN_BYTES)) begin
                res.obj_end = 1'b1;
                mark_nxt    = mark_dec;
                pos_nxt     = '0;
                phase_nxt   = (mark_dec != MK_NONE) ? PH_MARK : PH_IDLE;
              end else begin
                pos_nxt = pos_inc;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fill_r  <= '0;
      pos_r   <= '0;
      len_r   <= '0;
      mark_r  <= MK_NONE;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      mark_r  <= mark_nxt;
    end
  end

  // store writes only happen while filling, reads only while sending data
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st.we |-> (phase_r == PH_IDLE))
    else $error("store write outside idle phase");

  a_rd_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
    st.re |-> ((phase_r == PH_DATA) && (pos_r < fill_r)))
    else $error("store read outside data phase or above fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(BUFFER_BYTES))
    else $error("fill count beyond store depth");

  a_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (pos_r < len_r))
    else $error("data position past record length");

endmodule
